[rtl/sto_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sto_pkg;

    localparam int TABLE_INDEX_BITS = 10;
    localparam int PHASE_BITS       = 32;

    localparam int TABLE_LEN   = (2 ** TABLE_INDEX_BITS) + 1;
    localparam int STEP_BITS   = 32;
    localparam int VOLUME_BITS = 15;
    localparam int ENTRY_BITS  = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int TOP_BITS    = TABLE_INDEX_BITS + 2;

    localparam logic [STEP_BITS-1:0]   STEP_RESET   = 32'd68356571;
    localparam logic [VOLUME_BITS-1:0] VOLUME_RESET = '0;

    // register indexes on the config port
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME     = 2'd1;

    typedef logic [ENTRY_BITS-1:0] entry_t;
    typedef entry_t table_t [0:TABLE_LEN-1];

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(pi/2 * k / 2^T) in Q15, Taylor series in Q30 through the 15th power
    function automatic entry_t sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_INDEX_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        if (sum < 0)
        begin
            sum = '0;
        end
        q = (unsigned'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return ENTRY_BITS'(q);
    endfunction

    function automatic table_t build_table();
        table_t t;
        for (int k = 0; k < TABLE_LEN; k++)
        begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

[rtl/sto_sine_lut.sv]
`timescale 1ns / 1ps
`default_nettype none

// Quarter-wave fold and registered table read.
module sto_sine_lut (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [sto_pkg::TOP_BITS-1:0]  phase_top,
    output logic      [sto_pkg::ENTRY_BITS-1:0] entry_reg
);

    localparam sto_pkg::table_t QUARTER_TAB = sto_pkg::build_table();

    logic [1:0]                          quad;
    logic [sto_pkg::TABLE_INDEX_BITS:0]  offset;
    logic [sto_pkg::TABLE_INDEX_BITS:0]  idx;

    assign quad   = phase_top[sto_pkg::TOP_BITS-1 -: 2];
    assign offset = {1'b0, phase_top[sto_pkg::TABLE_INDEX_BITS-1:0]};

    // odd quadrants run the table backward
    always_comb
    begin
        if (quad[0])
        begin
            idx = (sto_pkg::TABLE_INDEX_BITS+1)'(2 ** sto_pkg::TABLE_INDEX_BITS) - offset;
        end
        else
        begin
            idx = offset;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= QUARTER_TAB[idx];
        end
    end

endmodule

`default_nettype wire

[rtl/sine_tone_oscillator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Phase-accumulator sine tone generator.
// Each item on the s_axis channel requests one sample; tdata bit 0 is the
// playing flag. The m_axis channel returns one signed 16-bit sample per item,
// in order. When playing, the sample is sin(phase) * volume truncated toward
// zero and the phase then advances by phase_step (one turn = 2^32). When
// stopped, the sample is zero and the phase holds.
// Pipeline: input register, quarter-wave table read, multiply into the
// output register. m_axis_tvalid rises once the item reaches the output
// register; one item per cycle is sustained while m_axis_tready stays high.
// Each stage advances on its own, so the block keeps taking items while a
// finished sample waits: s_axis_tready drops only once all three stages hold
// items and m_axis_tready is low.
// Config writes (cfg_valid, always ready) set phase_step (index 0) or volume
// (index 1); other indexes are ignored. Write only while the pipeline is empty.
// Reset clears the phase to zero, the step to 0.1 rad per sample, the volume
// to zero, and empties the pipeline.
module sine_tone_oscillator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] playing, [7:1] zero
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [sto_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int PB   = sto_pkg::PHASE_BITS;
    localparam int UP   = (PB >= 32) ? (PB - 32) : 0;
    localparam int DOWN = (PB < 32) ? (32 - PB) : 0;
    localparam int EXT  = PB + 32;

    logic [sto_pkg::STEP_BITS-1:0]   step_reg;
    logic [sto_pkg::VOLUME_BITS-1:0] volume_reg;
    logic [PB-1:0]                   phase_reg;
    logic [PB-1:0]                   phase_next;
    logic [PB-1:0]                   step_scaled;
    logic [EXT-1:0]                  step_ext;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;
    logic acc, adv12, adv23;

    logic [sto_pkg::TOP_BITS-1:0] top1_reg;
    logic                         play1_reg;
    logic                         play2_reg;
    logic                         neg2_reg;
    logic [sto_pkg::ENTRY_BITS-1:0] entry;

    logic [sto_pkg::ENTRY_BITS+sto_pkg::VOLUME_BITS-1:0] prod;
    logic [sto_pkg::ENTRY_BITS-1:0]  mag;
    logic [sto_pkg::SAMPLE_BITS-1:0] sample_next;
    logic [sto_pkg::SAMPLE_BITS-1:0] sample_reg;

    // handshake chain
    assign rdy3  = !v3_reg || m_axis_tready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign acc   = s_axis_tvalid && rdy1;
    assign adv12 = v1_reg && rdy2;
    assign adv23 = v2_reg && rdy3;

    assign v1_next = acc || (v1_reg && !rdy2);
    assign v2_next = adv12 || (v2_reg && !rdy3);
    assign v3_next = adv23 || (v3_reg && !m_axis_tready);

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = sample_reg;
    assign cfg_ready     = 1'b1;

    // step scaled to the phase width
    assign step_ext    = ({{PB{1'b0}}, step_reg} << UP) >> DOWN;
    assign step_scaled = step_ext[PB-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        if (acc && s_axis_tdata[0])
        begin
            phase_next = phase_reg + step_scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            step_reg   <= sto_pkg::STEP_RESET;
            volume_reg <= sto_pkg::VOLUME_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    sto_pkg::REG_PHASE_STEP: step_reg   <= cfg_data;
                    sto_pkg::REG_VOLUME:     volume_reg <= cfg_data[sto_pkg::VOLUME_BITS-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    // stage 1: phase snapshot
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            top1_reg  <= phase_reg[PB-1 -: sto_pkg::TOP_BITS];
            play1_reg <= s_axis_tdata[0];
        end
    end

    // stage 2: table read
    sto_sine_lut u_lut (
        .clk       (clk),
        .en        (adv12),
        .phase_top (top1_reg),
        .entry_reg (entry)
    );

    always_ff @(posedge clk)
    begin
        if (adv12)
        begin
            play2_reg <= play1_reg;
            neg2_reg  <= top1_reg[sto_pkg::TOP_BITS-1];
        end
    end

    // stage 3: scale by volume, truncate toward zero
    assign prod = {{sto_pkg::VOLUME_BITS{1'b0}}, entry}
                * {{sto_pkg::ENTRY_BITS{1'b0}}, volume_reg};
    assign mag  = prod[sto_pkg::ENTRY_BITS+sto_pkg::VOLUME_BITS-1 -: sto_pkg::ENTRY_BITS];

    always_comb
    begin
        if (!play2_reg)
        begin
            sample_next = '0;
        end
        else if (neg2_reg)
        begin
            sample_next = -{1'b0, mag};
        end
        else
        begin
            sample_next = {1'b0, mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv23)
        begin
            sample_reg <= sample_next;
        end
    end

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !s_axis_tdata[0]) |=> $stable(phase_reg))
        else $error("phase moved on a stopped item");

    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tdata[0]) |=> (phase_reg == $past(phase_reg + step_scaled)))
        else $error("phase did not advance by the step");

    a_silence: assert property (@(posedge clk) disable iff (!rst_n)
        (adv23 && !play2_reg) |=> (sample_reg == '0))
        else $error("stopped item gave a nonzero sample");

    a_zero_volume: assert property (@(posedge clk) disable iff (!rst_n)
        (adv23 && (volume_reg == '0)) |=> (sample_reg == '0))
        else $error("zero volume gave a nonzero sample");

endmodule

`default_nettype wire

[bench/tb_sine_tone_oscillator.sv]
`timescale 1ns / 1ps

module tb_sine_tone_oscillator;

    localparam logic [sto_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [sto_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 108;
    localparam int HOLD_CYCLES   = 400;

    typedef struct {
        logic [sto_pkg::CFG_INDEX_BITS-1:0] index;
        logic [31:0]                        data;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;     // [0] playing, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] sample
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [sto_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [31:0] cfg_data = 32'd0;

    // predictor state
    logic [14:0] sine_quarter [0:1024];
    logic [31:0] osc_phase  = 32'd0;
    logic [31:0] osc_step   = sto_pkg::STEP_RESET;
    logic [14:0] osc_volume = sto_pkg::VOLUME_RESET;

    logic        play_queue [$];
    logic [15:0] expected_samples [$];
    reg_write_t  reg_writes [$];

    int items_queued   = 0;
    int items_accepted = 0;
    int writes_issued  = 0;
    int writes_done    = 0;
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    logic pressure_go  = 1'b0;
    logic rx_hold      = 1'b0;

    sine_tone_oscillator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // sin(pi/2 * k / 1024) in Q15, Taylor series evaluated in Q30
    function automatic logic [14:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rounded;
        x    = (QUARTER_TURN_Q30 * 64'(k)) >> 10;
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (int n = 1; n < 15; n += 2)
        begin
            term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
            if (((n + 1) / 2) % 2 == 1)
            begin
                acc = acc - $signed(term);
            end
            else
            begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        rounded = ($unsigned(acc) + 64'd16384) >> 15;
        if (rounded > 64'd32767)
        begin
            rounded = 64'd32767;
        end
        return rounded[14:0];
    endfunction

    function automatic logic [15:0] predict_sample(input logic playing);
        logic [11:0] top;
        logic [10:0] entry_index;
        logic [29:0] product;
        logic [15:0] magnitude;
        if (!playing)
        begin
            return 16'd0;
        end
        top         = osc_phase[31:20];
        entry_index = {1'b0, top[9:0]};
        if (top[10])
        begin
            entry_index = 11'd1024 - entry_index;
        end
        product   = 30'(sine_quarter[entry_index]) * 30'(osc_volume);
        magnitude = {1'b0, product[29:15]};
        osc_phase = osc_phase + osc_step;
        return top[11] ? -magnitude : magnitude;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic queue_item(input logic playing);
        play_queue.push_back(playing);
        items_queued++;
    endtask

    task automatic set_reg(input logic [sto_pkg::CFG_INDEX_BITS-1:0] index,
                           input logic [31:0] data);
        reg_write_t w;
        w.index = index;
        w.data  = data;
        reg_writes.push_back(w);
        writes_issued++;
        wait (writes_done == writes_issued);
    endtask

    // wait until every requested sample has come back
    task automatic settle();
        wait (items_accepted == items_queued && expected_samples.size() == 0);
        @(posedge clk);
    endtask

    // sample requests
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_samples.push_back(predict_sample(s_axis_tdata[0]));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (play_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, play_queue.pop_front()};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // register writes
    always @(posedge clk)
    begin
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sto_pkg::REG_PHASE_STEP)
                begin
                    osc_step = cfg_data;
                end
                else if (cfg_index == sto_pkg::REG_VOLUME)
                begin
                    osc_volume = cfg_data[14:0];
                end
                writes_done++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    w = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // sample sink
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("sample %0d with no request pending",
                                          $signed(m_axis_tdata)));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_axis_tdata !== want)
                begin
                    report_mismatch($sformatf("sample got %0d expected %0d",
                                              $signed(m_axis_tdata), $signed(want)));
                end
            end
        end
    end

    // long sink stall so the pipeline backs up into the request side
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #2ms;
        $display("sine_tone_oscillator regression: fail");
        $finish;
    end

    initial
    begin
        logic [31:0] step;
        logic [31:0] vol;
        for (int k = 0; k <= 1024; k++)
        begin
            sine_quarter[k] = quarter_sine(k);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // quarter-turn steps from phase zero hit each quadrant boundary
        set_reg(sto_pkg::REG_PHASE_STEP, 32'h4000_0000);
        set_reg(sto_pkg::REG_VOLUME, 32'd32767);
        repeat (5) queue_item(1'b1);
        queue_item(1'b0);
        queue_item(1'b1);
        settle();

        // largest step wraps every sample; garbage above the volume width
        set_reg(sto_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        set_reg(sto_pkg::REG_VOLUME, 32'hFFFF_8001);
        repeat (3) queue_item(1'b1);
        settle();
        set_reg(REG_SPARE_2, $urandom());
        set_reg(REG_SPARE_3, $urandom());
        repeat (2) queue_item(1'b1);
        settle();

        // silent but still advancing
        set_reg(sto_pkg::REG_VOLUME, 32'd0);
        set_reg(sto_pkg::REG_PHASE_STEP, sto_pkg::STEP_RESET);
        queue_item(1'b1);
        queue_item(1'b0);
        settle();

        set_reg(sto_pkg::REG_PHASE_STEP, 32'd0);
        set_reg(sto_pkg::REG_VOLUME, 32'd16384);
        repeat (2) queue_item(1'b1);
        settle();

        // one table entry per sample
        set_reg(sto_pkg::REG_PHASE_STEP, 32'h0010_0000);
        set_reg(sto_pkg::REG_VOLUME, 32'd32767);
        repeat (4) queue_item(1'b1);
        settle();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 4)
            begin
                send_idle_pct <= 7;
                recv_idle_pct <= 78;
            end
            else if (seg < 8)
            begin
                send_idle_pct <= 78;
                recv_idle_pct <= 7;
            end
            else
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            case ($urandom_range(4))
                0: step = $urandom_range(1, 32'h00FF_FFFF);
                1: step = 32'd0;
                2: step = 32'hFFFF_FFFF;
                3: step = {12'($urandom_range(4095)), 20'd0};
                default: step = $urandom();
            endcase
            case ($urandom_range(4))
                0: vol = 32'd0;
                1: vol = 32'd32767;
                2: vol = $urandom();
                default: vol = $urandom_range(32767);
            endcase
            if ($urandom_range(1))
            begin
                set_reg(sto_pkg::REG_PHASE_STEP, step);
                set_reg(sto_pkg::REG_VOLUME, vol);
            end
            else
            begin
                set_reg(sto_pkg::REG_VOLUME, vol);
                set_reg(sto_pkg::REG_PHASE_STEP, step);
            end
            if ($urandom_range(3) == 0)
            begin
                set_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
            end
            if (seg == 9)
            begin
                pressure_go <= 1'b1;
            end
            for (int i = 0; i < SEGMENT_ITEMS; i++)
            begin
                queue_item($urandom_range(99) < 80);
            end
            settle();
        end

        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("sine_tone_oscillator regression: pass");
        end
        else
        begin
            $display("sine_tone_oscillator regression: fail");
        end
        $finish;
    end

endmodule

[sine_tone_oscillator.f]
rtl/sto_pkg.sv
rtl/sto_sine_lut.sv
rtl/sine_tone_oscillator.sv
bench/tb_sine_tone_oscillator.sv
